>>> sv/mbet_pkg.sv
// Package for the escape-time evaluator: shared widths, reset values, register indexes,
// the controller-to-datapath command and status structs, and the saturation helper.
// No dependencies.
package mbet_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_COORD_BITS = 10;
   localparam int DEF_FRAC_BITS  = 28;
   localparam int DEF_COUNT_BITS = 16;

   // Fixed word widths of the fixed-point datapath and the register port.
   localparam int DATA_BITS = 32;
   localparam int STEP_BITS = 31;
   localparam int PROD_BITS = 64;
   localparam int ADDR_BITS = 5;

   // Register reset values.
   localparam logic signed [DATA_BITS-1:0] ORIGIN_REAL_RESET = 32'shE000_0000;
   localparam logic signed [DATA_BITS-1:0] ORIGIN_IMAG_RESET = 32'shEA66_6666;
   localparam logic [STEP_BITS-1:0]        STEP_RESET        = 31'h000B_3333;
   localparam int                          LIMIT_RESET       = 50;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_ORIGIN_REAL = 3'd0,
      REG_ORIGIN_IMAG = 3'd1,
      REG_STEP_REAL   = 3'd2,
      REG_STEP_IMAG   = 3'd3,
      REG_ITER_LIMIT  = 3'd4
   } csr_index_type;

   // Operand selection for the shared multiplier.
   typedef enum logic [2:0] {
      MUL_ROW_STEP = 3'd0,
      MUL_COL_STEP = 3'd1,
      MUL_ZR_ZR    = 3'd2,
      MUL_ZI_ZI    = 3'd3,
      MUL_ZR_ZI    = 3'd4
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        start;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        load_cr;
      logic        load_ci;
      logic        load_rr;
      logic        load_ii;
      logic        update;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic limit_reached;
      logic escaped;
   } status_type;

   // Clamp a 64-bit signed value to the signed 32-bit range.
   function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [PROD_BITS-1:0] v);
      logic signed [PROD_BITS-1:0] max_v;
      logic signed [PROD_BITS-1:0] min_v;
      max_v = PROD_BITS'(32'sh7FFF_FFFF);
      min_v = PROD_BITS'(32'sh8000_0000);
      if (v > max_v) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_BITS-1:0];
      end
   endfunction

endpackage

>>> sv/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: register file, controller and datapath.
// Depends on mbet_pkg, mbet_csr, mbet_ctrl and mbet_datapath.
//
// Each accepted pixel (row, column) is mapped to c = origin + index * step in signed fixed
// point with FRAC_BITS fraction bits, and z = z*z + c is iterated from zero until |z|^2
// exceeds 4 or the count reaches iteration_limit. One pixel is evaluated at a time. The
// pixel is mapped in the states MAP_RE, MAP_IM and SET_CI, and each iteration runs
// through SQ_R, SQ_I, CROSS and UPDATE, since one shared 32x32 multiplier forms zr*zr,
// zi*zi and zr*zi in turn, with the update in a state of its own. A pixel that reaches
// the limit goes to the result load from SQ_R, while one that escapes goes there from
// UPDATE, after the escaping iteration has formed its squares but not its z update. The
// next pixel can be taken in the cycle after the result load. A finished result waits in
// an output register, so the next pixel is taken while the previous result is still
// waiting to be collected; a second result waits for the first to leave. Registers are
// at byte addresses 0 (origin_real), 4 (origin_imag), 8 (step_real), 12 (step_imag) and
// 16 (iteration_limit), and are to be written only while no pixel is in flight.
module mandelbrot_escape_time import mbet_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + COUNT_BITS + 1 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,    // pixel_row, pixel_col
   // Result channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,    // out_row, out_col, iteration_count, inside_set
   // Configuration port.
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   logic signed [DATA_BITS-1:0] origin_real, origin_imag;
   logic [STEP_BITS-1:0]        step_real, step_imag;
   logic [COUNT_BITS-1:0]       iteration_limit;
   logic [COORD_BITS-1:0]       pixel_row, pixel_col;
   logic [COORD_BITS-1:0]       out_row, out_col;
   logic [COUNT_BITS-1:0]       iteration_count;
   logic                        inside_set;
   cmd_type                     cmd;
   status_type                  status;

   // Unpack the input transfer and pack the result transfer.
   assign pixel_row = req_tdata[COORD_BITS-1:0];
   assign pixel_col = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign rsp_tdata = RSP_W'({inside_set, iteration_count, out_col, out_row});

   mbet_csr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .origin_real     (origin_real),
      .origin_imag     (origin_imag),
      .step_real       (step_real),
      .step_imag       (step_imag),
      .iteration_limit (iteration_limit)
   );

   mbet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbet_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .origin_real     (origin_real),
      .origin_imag     (origin_imag),
      .step_real       (step_real),
      .step_imag       (step_imag),
      .iteration_limit (iteration_limit),
      .pixel_row       (pixel_row),
      .pixel_col       (pixel_col),
      .cmd             (cmd),
      .status          (status),
      .out_row         (out_row),
      .out_col         (out_col),
      .iteration_count (iteration_count),
      .inside_set      (inside_set)
   );

endmodule

>>> sv/mbet_csr.sv
// Configuration register file with an APB-style slave port.
// Depends on mbet_pkg for widths, reset values and register indexes.
module mbet_csr import mbet_pkg::*; #(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_BITS-1:0]         csr_paddr,
   input  logic [DATA_BITS-1:0]         csr_pwdata,
   output logic [DATA_BITS-1:0]         csr_prdata,
   output logic                         csr_pready,
   output logic signed [DATA_BITS-1:0]  origin_real,
   output logic signed [DATA_BITS-1:0]  origin_imag,
   output logic [STEP_BITS-1:0]         step_real,
   output logic [STEP_BITS-1:0]         step_imag,
   output logic [COUNT_BITS-1:0]        iteration_limit
);

   logic signed [DATA_BITS-1:0] origin_real_ff, origin_real_in;
   logic signed [DATA_BITS-1:0] origin_imag_ff, origin_imag_in;
   logic [STEP_BITS-1:0]        step_real_ff, step_real_in;
   logic [STEP_BITS-1:0]        step_imag_ff, step_imag_in;
   logic [COUNT_BITS-1:0]       limit_ff, limit_in;
   logic                        wr_en;
   csr_index_type               index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[ADDR_BITS-1:2]);

   // Next register values on a completed write transfer; other addresses are ignored.
   always_comb begin
      origin_real_in = origin_real_ff;
      origin_imag_in = origin_imag_ff;
      step_real_in   = step_real_ff;
      step_imag_in   = step_imag_ff;
      limit_in       = limit_ff;
      if (wr_en) begin
         case (index)
            REG_ORIGIN_REAL: origin_real_in = csr_pwdata;
            REG_ORIGIN_IMAG: origin_imag_in = csr_pwdata;
            REG_STEP_REAL:   step_real_in   = csr_pwdata[STEP_BITS-1:0];
            REG_STEP_IMAG:   step_imag_in   = csr_pwdata[STEP_BITS-1:0];
            REG_ITER_LIMIT:  limit_in       = csr_pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_real_ff <= ORIGIN_REAL_RESET;
         origin_imag_ff <= ORIGIN_IMAG_RESET;
         step_real_ff   <= STEP_RESET;
         step_imag_ff   <= STEP_RESET;
         limit_ff       <= COUNT_BITS'(LIMIT_RESET);
      end else begin
         origin_real_ff <= origin_real_in;
         origin_imag_ff <= origin_imag_in;
         step_real_ff   <= step_real_in;
         step_imag_ff   <= step_imag_in;
         limit_ff       <= limit_in;
      end
   end

   // Read data for the addressed register.
   always_comb begin
      case (index)
         REG_ORIGIN_REAL: csr_prdata = origin_real_ff;
         REG_ORIGIN_IMAG: csr_prdata = origin_imag_ff;
         REG_STEP_REAL:   csr_prdata = DATA_BITS'(step_real_ff);
         REG_STEP_IMAG:   csr_prdata = DATA_BITS'(step_imag_ff);
         REG_ITER_LIMIT:  csr_prdata = DATA_BITS'(limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign origin_real     = origin_real_ff;
   assign origin_imag     = origin_imag_ff;
   assign step_real       = step_real_ff;
   assign step_imag       = step_imag_ff;
   assign iteration_limit = limit_ff;

endmodule

>>> sv/mbet_datapath.sv
// Datapath: shared 32x32 multiplier, point mapping, z update, escape test and result register.
// Depends on mbet_pkg for the command and status structs and the saturation helper.
module mbet_datapath import mbet_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                        clock,
   input  logic signed [DATA_BITS-1:0] origin_real,
   input  logic signed [DATA_BITS-1:0] origin_imag,
   input  logic [STEP_BITS-1:0]        step_real,
   input  logic [STEP_BITS-1:0]        step_imag,
   input  logic [COUNT_BITS-1:0]       iteration_limit,
   input  logic [COORD_BITS-1:0]       pixel_row,
   input  logic [COORD_BITS-1:0]       pixel_col,
   input  cmd_type                     cmd,
   output status_type                  status,
   output logic [COORD_BITS-1:0]       out_row,
   output logic [COORD_BITS-1:0]       out_col,
   output logic [COUNT_BITS-1:0]       iteration_count,
   output logic                        inside_set
);

   // A square shifted down by the fraction bits fits in this many signed bits.
   localparam int SQ_BITS = PROD_BITS - FRAC_BITS;
   localparam logic signed [PROD_BITS-1:0] THRESH = 64'sd4 <<< FRAC_BITS;

   logic [COORD_BITS-1:0]        row_ff, col_ff;
   logic signed [DATA_BITS-1:0]  cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [DATA_BITS-1:0]  zr_in, zi_in;
   logic signed [SQ_BITS-1:0]    rr_ff, ii_ff;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]  sq_shift, cross_shift;
   logic signed [PROD_BITS-1:0]  rr_ext, ii_ext, mag_sum;
   logic [COUNT_BITS-1:0]        count_ff;
   logic signed [DATA_BITS-1:0]  mul_a, mul_b;
   logic [COORD_BITS-1:0]        out_row_ff, out_col_ff;
   logic [COUNT_BITS-1:0]        out_count_ff;
   logic                         out_inside_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         MUL_ROW_STEP: begin
            mul_a = DATA_BITS'(row_ff);
            mul_b = DATA_BITS'(step_real);
         end
         MUL_COL_STEP: begin
            mul_a = DATA_BITS'(col_ff);
            mul_b = DATA_BITS'(step_imag);
         end
         MUL_ZR_ZR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         MUL_ZI_ZI: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         MUL_ZR_ZI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Products are floored by arithmetic shifts; the cross term keeps one more bit to double it.
   assign sq_shift    = prod_ff >>> FRAC_BITS;
   assign cross_shift = prod_ff >>> (FRAC_BITS - 1);
   assign rr_ext      = {{FRAC_BITS{rr_ff[SQ_BITS-1]}}, rr_ff};
   assign ii_ext      = {{FRAC_BITS{ii_ff[SQ_BITS-1]}}, ii_ff};
   assign mag_sum     = rr_ext + ii_ext;

   assign zr_in = sat32(rr_ext - ii_ext + PROD_BITS'(cr_ff));
   assign zi_in = sat32(cross_shift + PROD_BITS'(ci_ff));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff   <= pixel_row;
         col_ff   <= pixel_col;
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= COUNT_BITS'(count_ff + 1'b1);
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_cr) begin
         cr_ff <= sat32(PROD_BITS'(origin_real) + prod_ff);
      end
      if (cmd.load_ci) begin
         ci_ff <= sat32(PROD_BITS'(origin_imag) + prod_ff);
      end
      if (cmd.load_rr) begin
         rr_ff <= sq_shift[SQ_BITS-1:0];
      end
      if (cmd.load_ii) begin
         ii_ff <= sq_shift[SQ_BITS-1:0];
      end
   end

   // Result register: holds a finished pixel until the output transfer.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_row_ff    <= row_ff;
         out_col_ff    <= col_ff;
         out_count_ff  <= count_ff;
         out_inside_ff <= (count_ff >= iteration_limit);
      end
   end

   assign status.limit_reached = (count_ff >= iteration_limit);
   assign status.escaped       = (mag_sum > THRESH);

   assign out_row         = out_row_ff;
   assign out_col         = out_col_ff;
   assign iteration_count = out_count_ff;
   assign inside_set      = out_inside_ff;

endmodule

>>> sv/mbet_ctrl.sv
// Controller: one-hot state machine that sequences mapping, iterations and result hand-off.
// Depends on mbet_pkg for the command and status structs.
module mbet_ctrl import mbet_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_MAP_RE = 9'b0_0000_0010,
      ST_MAP_IM = 9'b0_0000_0100,
      ST_SET_CI = 9'b0_0000_1000,
      ST_SQ_R   = 9'b0_0001_0000,
      ST_SQ_I   = 9'b0_0010_0000,
      ST_CROSS  = 9'b0_0100_0000,
      ST_UPDATE = 9'b0_1000_0000,
      ST_DONE   = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new pixel when empty or being emptied this cycle.
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_ZR_ZI;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_MAP_RE;
            end
         end
         ST_MAP_RE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW_STEP;
            state_in    = ST_MAP_IM;
         end
         ST_MAP_IM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_COL_STEP;
            cmd.load_cr = 1'b1;
            state_in    = ST_SET_CI;
         end
         ST_SET_CI: begin
            cmd.load_ci = 1'b1;
            state_in    = ST_SQ_R;
         end
         ST_SQ_R: begin
            if (status.limit_reached) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_ZR_ZR;
               state_in    = ST_SQ_I;
            end
         end
         ST_SQ_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ZI_ZI;
            cmd.load_rr = 1'b1;
            state_in    = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ZR_ZI;
            cmd.load_ii = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.escaped) begin
               state_in = ST_DONE;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_SQ_R;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid: set on a result load, cleared by the output transfer.
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> tb/escape_time_checker.sv
`timescale 1ns / 100ps
// Checker for the escape-time evaluator: watches the pixel, result and register channels,
// predicts each result from its own copy of the registers and compares. Depends on mbet_pkg.
module escape_time_checker import mbet_pkg::*; #(
   parameter int REQ_W = 24,
   parameter int RSP_W = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,    // pixel_row, pixel_col
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,    // out_row, out_col, iteration_count, inside_set
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   input  logic                 csr_pready,
   output int                   mismatch_count,
   output int                   pixels_in_flight
);

   localparam int CB = DEF_COORD_BITS;
   localparam int FB = DEF_FRAC_BITS;
   localparam int NB = DEF_COUNT_BITS;

   typedef struct {
      logic [CB-1:0] row;
      logic [CB-1:0] col;
      logic [NB-1:0] count;
      logic          in_set;
   } pixel_result_type;

   pixel_result_type results_due[$];

   // Shadow copy of the register file, updated from observed write transfers.
   logic signed [DATA_BITS-1:0] origin_re;
   logic signed [DATA_BITS-1:0] origin_im;
   logic [STEP_BITS-1:0]        step_re;
   logic [STEP_BITS-1:0]        step_im;
   logic [NB-1:0]               iter_limit;

   initial begin
      mismatch_count   = 0;
      pixels_in_flight = 0;
   end

   // Limit a wide value to the signed 32-bit word range.
   function automatic longint clamp_word(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Iterate z = z*z + c from zero for one pixel under the current register values.
   function automatic pixel_result_type escape_time(input logic [CB-1:0] row,
                                                    input logic [CB-1:0] col);
      longint           cr;
      longint           ci;
      longint           zr;
      longint           zi;
      longint           rr;
      longint           ii;
      longint           cross_term;
      int unsigned      n;
      bit               escaped;
      pixel_result_type res;
      cr = clamp_word(longint'(origin_re) + longint'(row) * longint'(step_re));
      ci = clamp_word(longint'(origin_im) + longint'(col) * longint'(step_im));
      zr = 0;
      zi = 0;
      n = 0;
      escaped = 1'b0;
      while (n < iter_limit && !escaped) begin
         // Squares and the cross term are floored, which the arithmetic shift gives.
         rr = (zr * zr) >>> FB;
         ii = (zi * zi) >>> FB;
         if (rr + ii > (64'sd4 <<< FB)) begin
            escaped = 1'b1;
         end else begin
            cross_term = (zr * zi) >>> (FB - 1);
            zr = clamp_word(rr - ii + cr);
            zi = clamp_word(cross_term + ci);
            n++;
         end
      end
      res.row    = row;
      res.col    = col;
      res.count  = n[NB-1:0];
      res.in_set = (n >= iter_limit);
      return res;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Sample every channel at the clock edge: results are compared before new pixels are
   // queued, since a result can never belong to a pixel taken at the same edge.
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         results_due.delete();
         origin_re  = ORIGIN_REAL_RESET;
         origin_im  = ORIGIN_IMAG_RESET;
         step_re    = STEP_RESET;
         step_im    = STEP_RESET;
         iter_limit = NB'(LIMIT_RESET);
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[ADDR_BITS-1:2]))
               REG_ORIGIN_REAL: begin
                  origin_re = csr_pwdata;
               end
               REG_ORIGIN_IMAG: begin
                  origin_im = csr_pwdata;
               end
               REG_STEP_REAL: begin
                  step_re = csr_pwdata[STEP_BITS-1:0];
               end
               REG_STEP_IMAG: begin
                  step_im = csr_pwdata[STEP_BITS-1:0];
               end
               REG_ITER_LIMIT: begin
                  iter_limit = csr_pwdata[NB-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("result transfer with no pixel outstanding");
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               check_field("out_row", want.row, rsp_tdata[CB-1:0]);
               check_field("out_col", want.col, rsp_tdata[2*CB-1:CB]);
               check_field("iteration_count", want.count, rsp_tdata[2*CB+NB-1:2*CB]);
               check_field("inside_set", want.in_set, rsp_tdata[2*CB+NB]);
            end
         end
         if (req_tvalid && req_tready) begin
            results_due.push_back(escape_time(req_tdata[CB-1:0], req_tdata[2*CB-1:CB]));
         end
      end
      pixels_in_flight = results_due.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the escape-time evaluator testbench: clock, reset, pixel and register stimulus
// and the verdict. Depends on mbet_pkg, mandelbrot_escape_time and escape_time_checker.
module testbench;
   import mbet_pkg::*;

   localparam int CB    = DEF_COORD_BITS;
   localparam int REQ_W = ((2 * CB + 7) / 8) * 8;
   localparam int RSP_W = ((2 * CB + DEF_COUNT_BITS + 1 + 7) / 8) * 8;
   localparam int PIX_MAX = (1 << CB) - 1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [DATA_BITS-1:0] csr_pwdata = '0;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   int mismatch_count;
   int pixels_in_flight;
   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   bit quiet = 1'b0;

   mandelbrot_escape_time uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   escape_time_checker #(.REQ_W(REQ_W), .RSP_W(RSP_W)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 0;
   end

   // Offer one pixel, sometimes after an idle burst, and hold it until its transfer.
   task automatic send_pixel(input int row, input int col);
      if (sender_idle && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({col[CB-1:0], row[CB-1:0]});
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering pixels and wait until every outstanding result has been collected.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pixels_in_flight != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Write all five registers, each with a setup phase and then an access phase.
   task automatic load_config(input logic [31:0] org_re, input logic [31:0] org_im,
                              input logic [31:0] stp_re, input logic [31:0] stp_im,
                              input logic [31:0] limit);
      logic [31:0]   values[5];
      csr_index_type regs[5];
      values = '{org_re, org_im, stp_re, stp_im, limit};
      regs   = '{REG_ORIGIN_REAL, REG_ORIGIN_IMAG, REG_STEP_REAL, REG_STEP_IMAG,
                 REG_ITER_LIMIT};
      for (int i = 0; i < 5; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {regs[i], 2'b00};
         csr_pwdata  <= values[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Result side: ready in runs of random length, broken by stall bursts when allowed.
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         if (receiver_idle && !quiet) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   initial begin
      int          kind;
      logic [31:0] org_re;
      logic [31:0] org_im;
      logic [31:0] stp_re;
      logic [31:0] stp_im;
      logic [31:0] limit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset view: corners, points deep inside the set and points that escape at once.
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      send_pixel(0, PIX_MAX);
      send_pixel(PIX_MAX, 0);
      send_pixel(732, 494);
      send_pixel(600, 494);
      send_pixel(100, 300);
      send_pixel(1, 1);

      // Extreme origins and steps, with the step's unused top bit set: c saturates.
      wait_drained();
      load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      send_pixel(PIX_MAX, 0);
      send_pixel(0, PIX_MAX);

      // Zero limit, written with junk above the limit field: no iteration at all.
      wait_drained();
      load_config(32'hE000_0000, 32'hEA66_6666, 32'h000B_3333, 32'h000B_3333, 32'hFFFF_0000);
      send_pixel(5, 5);
      send_pixel(PIX_MAX, PIX_MAX);

      // Largest limit: c = 0 runs to the limit, c = 0.5 escapes, the far row saturates.
      wait_drained();
      load_config(32'h0000_0000, 32'h0000_0000, 32'h0800_0000, 32'h0000_0000, 32'h0000_FFFF);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(PIX_MAX, 0);

      // c = -2 sits exactly on the escape bound and never leaves; its neighbours do.
      wait_drained();
      load_config(32'hE000_0000, 32'h0000_0000, 32'h0800_0000, 32'h0400_0000, 32'd20);
      send_pixel(0, 0);
      send_pixel(0, 1);
      send_pixel(8, 0);

      // Random phases: mostly windows over the set, some wild settings; the last two
      // phases run without any idling.
      for (int ph = 0; ph < 17; ph++) begin
         wait_drained();
         if (ph >= 15) begin
            quiet = 1'b1;
         end else begin
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
         end
         kind = $urandom_range(0, 7);
         if (kind < 6) begin
            org_re = 32'(-671088640 + int'($urandom_range(0, 536870912)));
            org_im = 32'(-402653184 + int'($urandom_range(0, 268435456)));
            if ($urandom_range(0, 3) == 0) begin
               stp_re = $urandom_range(0, 4096);
               stp_im = $urandom_range(0, 4096);
            end else begin
               stp_re = $urandom_range(1, 786432);
               stp_im = $urandom_range(1, 786432);
            end
            limit = $urandom_range(1, 64);
         end else begin
            org_re = $urandom;
            org_im = $urandom;
            stp_re = $urandom;
            stp_im = $urandom;
            limit  = {16'($urandom), 16'($urandom_range(0, 64))};
         end
         load_config(org_re, org_im, stp_re, stp_im, limit);
         repeat (100) send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && pixels_in_flight == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
